>>> rtl/core/medn_pkg.sv
`default_nettype none
package medn_pkg;
  localparam int unsigned NodeW = 12;
  localparam int unsigned EdgeW = 14;
  localparam int unsigned GidxW = 31;
  localparam int unsigned ShrW = 16;
  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned MaxEdgesPerNode = 8;
  localparam int unsigned MaxEdges = 16384;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 96;

  typedef struct packed {
    logic [1:0]       slot;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    logic             last;
  } side_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_RDA, S_SCAN, S_WRA, S_WRB, S_OUT, S_CLR
  } be_state_e;
endpackage
`default_nettype wire

>>> rtl/core/mesh_edge_dedup_numbering.sv
`default_nettype none
// Edge extraction: each element item yields three (triangle) or four (quad) side
// items in side order, tlast on the final one. The front takes an element and
// splits it into a four-entry side queue, so the next element is taken while the
// back still works. The back reads the list lengths of a side's two nodes, loads
// the second node's edge list, scans the first node's list for a match and, for a
// new edge, writes it to both lists, reading the single-port edge list store one
// entry per cycle. Output stalls hold the back until the side is taken. After
// reset the per-node counts are cleared before the first side is taken.
module mesh_edge_dedup_numbering import medn_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodes,
  parameter int unsigned MAX_EDGES_PER_NODE = MaxEdgesPerNode,
  parameter int unsigned MAX_EDGES = MaxEdges
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [GidxW-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,   // corner0..corner3
  input  wire logic                 s_axis_tuser,   // is_triangle
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // side_slot, edge_number, is_new, first_node, second_node, global_index,
  // shared_total, overflow
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic                      m_axis_tlast
);
  logic [GidxW-1:0] base_q;
  logic sv, sr;
  side_t sd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= GidxW'(1);
    else if (cfg_we_i) base_q <= cfg_wdata_i;
  end

  medn_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .c0_i(s_axis_tdata[11:0]), .c1_i(s_axis_tdata[23:12]),
    .c2_i(s_axis_tdata[35:24]), .c3_i(s_axis_tdata[47:36]), .tri_i(s_axis_tuser),
    .side_valid_o(sv), .side_ready_i(sr), .side_o(sd)
  );

  medn_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES_PER_NODE(MAX_EDGES_PER_NODE),
              .MAX_EDGES(MAX_EDGES)) u_back (
    .clk_i, .rst_ni, .base_i(base_q), .side_valid_i(sv), .side_ready_o(sr),
    .side_i(sd), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_new_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[88]))
    else $error("new and overflow together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
`endif
endmodule
`default_nettype wire

>>> rtl/core/medn_front.sv
`default_nettype none
// splits an element into sides and queues them
module medn_front import medn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [NodeW-1:0]  c0_i,
  input  wire logic [NodeW-1:0]  c1_i,
  input  wire logic [NodeW-1:0]  c2_i,
  input  wire logic [NodeW-1:0]  c3_i,
  input  wire logic              tri_i,
  output logic                   side_valid_o,
  input  wire logic              side_ready_i,
  output side_t                  side_o
);
  localparam int unsigned QDepth = 4;
  side_t       q_q [QDepth];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic [NodeW-1:0] cr_q [4];
  logic        tri_q, busy_q;
  logic [1:0]  f_q;
  side_t       cur;
  logic        push, pop;

  always_comb begin
    cur.slot = f_q;
    cur.a = cr_q[f_q];
    if (tri_q && f_q == 2'd2) cur.b = cr_q[0];
    else cur.b = cr_q[f_q + 2'd1];
    cur.last = tri_q ? (f_q == 2'd2) : (f_q == 2'd3);
  end

  assign in_ready_o = !busy_q;
  assign push = busy_q && cnt_q != 3'(QDepth);
  assign pop = side_valid_o && side_ready_i;
  assign side_valid_o = cnt_q != 3'd0;
  assign side_o = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cr_q[0] <= c0_i; cr_q[1] <= c1_i; cr_q[2] <= c2_i; cr_q[3] <= c3_i;
      tri_q <= tri_i;
    end
    if (push) q_q[wp_q] <= cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; f_q <= '0; wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1; f_q <= '0;
      end else if (push) begin
        f_q <= f_q + 2'd1;
        if (cur.last) busy_q <= 1'b0;
      end
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/medn_back.sv
`default_nettype none
// searches and updates the per-node edge lists, one side at a time
module medn_back import medn_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodes,
  parameter int unsigned MAX_EDGES_PER_NODE = MaxEdgesPerNode,
  parameter int unsigned MAX_EDGES = MaxEdges
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [GidxW-1:0]  base_i,
  input  wire logic              side_valid_i,
  output logic                   side_ready_o,
  input  side_t                  side_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [OutDataW-1:0]    out_data_o,
  output logic                   out_last_o
);
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned LW = (MAX_EDGES_PER_NODE > 1) ? $clog2(MAX_EDGES_PER_NODE) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES_PER_NODE + 1);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NodeRange = 1 << NodeW;

  logic [EdgeW-1:0] lst_mem [MAX_NODES << LW];
  logic [CW-1:0]    cnt_mem [MAX_NODES];

  be_state_e st_q, st_d;
  side_t     s_q;
  logic [NW-1:0] clr_q;
  logic [CW-1:0] ca_q, cb_q;
  logic [EdgeW-1:0] bl_q [MAX_EDGES_PER_NODE];
  logic [CW-1:0] j_q;
  logic rdv_q;
  logic [EdgeW-1:0] rd_q, edge_q;
  logic [ECW-1:0] ecnt_q;
  logic [ShrW-1:0] shr_q;
  logic new_q, ovf_q;
  logic found, match, full;
  logic a_ok, b_ok, same;
  logic [NW-1:0] na, nb;
  logic [GidxW:0] sum;
  logic [GidxW-1:0] gidx;

  assign na = NW'(s_q.a);
  assign nb = NW'(s_q.b);
  assign same = s_q.a == s_q.b;
  assign a_ok = NodeRange <= MAX_NODES || 32'(s_q.a) < MAX_NODES;
  assign b_ok = NodeRange <= MAX_NODES || 32'(s_q.b) < MAX_NODES;

  always_comb begin
    found = 1'b0;
    for (int k = 0; k < MAX_EDGES_PER_NODE; k++)
      if (CW'(k) < cb_q && bl_q[k] == rd_q) found = 1'b1;
  end

  // rd_q holds a entry j-1 while entry j is read
  assign match = rdv_q && found;
  assign full = 32'(ecnt_q) >= MAX_EDGES
                || 32'(ca_q) + (same ? 32'd2 : 32'd1) > MAX_EDGES_PER_NODE
                || 32'(cb_q) + 32'd1 > MAX_EDGES_PER_NODE;

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && side_valid_i) s_q <= side_i;
    if (st_q == S_CNT) begin
      ca_q <= cnt_mem[na];
      cb_q <= cnt_mem[nb];
    end
    if (st_q == S_RDA && j_q < cb_q) bl_q[LW'(j_q)] <= lst_mem[{nb, LW'(j_q)}];
    if (st_q == S_SCAN && j_q < ca_q) rd_q <= lst_mem[{na, LW'(j_q)}];
    if (st_q == S_CLR) cnt_mem[clr_q] <= '0;
    if (st_q == S_WRA) begin
      lst_mem[{na, LW'(ca_q)}] <= edge_q;
      cnt_mem[na] <= ca_q + CW'(1);
    end
    if (st_q == S_WRB) begin
      // a side with both ends on one node takes two slots of that list
      if (same) begin
        lst_mem[{na, LW'(ca_q + CW'(1))}] <= edge_q;
        cnt_mem[na] <= ca_q + CW'(2);
      end else begin
        lst_mem[{nb, LW'(cb_q)}] <= edge_q;
        cnt_mem[nb] <= cb_q + CW'(1);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    side_ready_o = st_q == S_IDLE;
    unique case (st_q)
      S_CLR: if (32'(clr_q) == MAX_NODES - 1) st_d = S_IDLE;
      S_IDLE: if (side_valid_i) st_d = S_CNT;
      S_CNT: st_d = S_RDA;
      S_RDA: begin
        // load b list, then scan a entries one per cycle
        if (!a_ok || !b_ok) st_d = S_OUT;
        else if (j_q >= cb_q) st_d = S_SCAN;
      end
      S_SCAN: begin
        if (match) st_d = S_OUT;
        else if (j_q >= ca_q) st_d = full ? S_OUT : S_WRA;
      end
      S_WRA: st_d = S_WRB;
      S_WRB: st_d = S_OUT;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
    endcase
  end

  assign sum = {1'b0, base_i} + (GidxW+1)'(edge_q);
  assign gidx = ovf_q ? '0 : (sum[GidxW] ? '1 : sum[GidxW-1:0]);
  assign out_valid_o = st_q == S_OUT;
  assign out_last_o = s_q.last;
  assign out_data_o = {7'd0, ovf_q, shr_q, gidx, s_q.b, s_q.a, new_q, edge_q, s_q.slot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; j_q <= '0; rdv_q <= 1'b0;
      ecnt_q <= '0; shr_q <= '0; new_q <= 1'b0; ovf_q <= 1'b0; edge_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLR) clr_q <= clr_q + NW'(1);
      if (st_q == S_CNT) begin
        j_q <= '0; rdv_q <= 1'b0;
        new_q <= 1'b0; ovf_q <= 1'b0; edge_q <= '0;
      end
      if (st_q == S_RDA) begin
        if (!a_ok || !b_ok) ovf_q <= 1'b1;
        else if (j_q < cb_q) j_q <= j_q + CW'(1);
        else j_q <= '0;
      end
      if (st_q == S_SCAN) begin
        if (match) begin
          edge_q <= rd_q;
          if (shr_q != '1) shr_q <= shr_q + ShrW'(1);
        end else if (j_q < ca_q) begin
          j_q <= j_q + CW'(1);
          rdv_q <= 1'b1;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          edge_q <= EdgeW'(ecnt_q); new_q <= 1'b1;
          ecnt_q <= ecnt_q + ECW'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire
